// ----- sv/sbe_pkg.sv -----
// Shared types, opcodes and status codes of the stack bit expression evaluator.
package sbe_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int PIN_SLOTS_DEF   = 16;
  localparam int CONST_SLOTS_DEF = 16;

  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 3;
  localparam int OPER_W  = 2;
  localparam int CFG_IDX_W = 1;

  // item operations
  localparam logic [OPER_W-1:0] OPN_PIN   = 2'd0;
  localparam logic [OPER_W-1:0] OPN_CONST = 2'd1;
  localparam logic [OPER_W-1:0] OPN_CODE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_COUNT = 1'd1;

  // opcodes
  localparam logic [BYTE_W-1:0] OP_END    = 8'd0;
  localparam logic [BYTE_W-1:0] OP_DUP    = 8'd1;
  localparam logic [BYTE_W-1:0] OP_DROP   = 8'd2;
  localparam logic [BYTE_W-1:0] OP_SWAP   = 8'd3;
  localparam logic [BYTE_W-1:0] OP_IN     = 8'd4;
  localparam logic [BYTE_W-1:0] OP_K      = 8'd5;
  localparam logic [BYTE_W-1:0] OP_AND    = 8'd6;
  localparam logic [BYTE_W-1:0] OP_OR     = 8'd7;
  localparam logic [BYTE_W-1:0] OP_XOR    = 8'd8;
  localparam logic [BYTE_W-1:0] OP_SHL    = 8'd9;
  localparam logic [BYTE_W-1:0] OP_SHR    = 8'd10;
  localparam logic [BYTE_W-1:0] OP_SAR    = 8'd11;
  localparam logic [BYTE_W-1:0] OP_ROL    = 8'd12;
  localparam logic [BYTE_W-1:0] OP_ROR    = 8'd13;
  localparam logic [BYTE_W-1:0] OP_GET    = 8'd14;
  localparam logic [BYTE_W-1:0] OP_SET    = 8'd15;
  localparam logic [BYTE_W-1:0] OP_CLR    = 8'd16;
  localparam logic [BYTE_W-1:0] OP_TGL    = 8'd17;
  localparam logic [BYTE_W-1:0] OP_NOT    = 8'd18;
  localparam logic [BYTE_W-1:0] OP_POPCNT = 8'd19;
  localparam logic [BYTE_W-1:0] OP_CLZ    = 8'd20;
  localparam logic [BYTE_W-1:0] OP_CTZ    = 8'd21;
  localparam logic [BYTE_W-1:0] OP_BSWAP  = 8'd22;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_OPCODE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OPERAND = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVER    = 3'd4;
  localparam logic [STAT_W-1:0] ST_DEPTH   = 3'd5;

  typedef enum logic [2:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_SWAP,
    STK_REPL,
    STK_BIN
  } stk_cmd_e;

  typedef struct packed {
    stk_cmd_e            cmd;
    logic                clear;
    logic [WORD_W-1:0]   data;
  } stk_ctl_t;

endpackage

// ----- sv/sbe_if.sv -----
// Valid/ready channel interfaces for evaluator items and results.
interface sbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  slot;
  logic [31:0] value;
  logic [7:0]  code_byte;
  logic        last;

  modport source (output valid, operation, slot, value, code_byte, last, input ready);
  modport sink   (input valid, operation, slot, value, code_byte, last, output ready);
endinterface

interface sbe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic [2:0]  status;
  logic [15:0] error_position;
  logic [7:0]  error_opcode;

  modport source (output valid, result, status, error_position, error_opcode, input ready);
  modport sink   (input valid, result, status, error_position, error_opcode, output ready);
endinterface

// ----- sv/sbe_slot_ram.sv -----
// Slot table memory for pin values or constants, one write and one registered read port.
module sbe_slot_ram import sbe_pkg::*; #(
  parameter int SLOTS = PIN_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [BYTE_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [WORD_W-1:0] mem [SLOTS];
  logic [AW-1:0]     wa;
  logic [AW-1:0]     ra;
  logic              wr_ok;

  assign wa    = AW'(waddr_i);
  assign ra    = AW'(raddr_i);
  assign wr_ok = 32'(waddr_i) < SLOTS;

  always_ff @(posedge clk_i) begin
    if (we_i && wr_ok) begin
      mem[wa] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[ra];
    end
  end

endmodule

// ----- sv/sbe_alu.sv -----
// Bit operation unit: binary operations on next and top, unary operations on top.
module sbe_alu import sbe_pkg::*; (
  input  logic [BYTE_W-1:0] op_i,
  input  logic [WORD_W-1:0] x_i,
  input  logic [WORD_W-1:0] y_i,
  output logic [WORD_W-1:0] res_o
);

  logic [4:0]        n;
  logic              sat;
  logic [WORD_W-1:0] bit_mask;
  logic [5:0]        lz;
  logic [5:0]        tz;

  assign n        = y_i[4:0];
  assign sat      = |y_i[WORD_W-1:5];
  assign bit_mask = WORD_W'(1) << n;

  always_comb begin
    lz = 6'd32;
    tz = 6'd32;
    for (int i = 0; i < WORD_W; i++) begin
      if (y_i[i]) begin
        lz = 6'(WORD_W - 1 - i);
      end
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (y_i[i]) begin
        tz = 6'(i);
      end
    end
  end

  always_comb begin
    case (op_i)
      OP_AND:    res_o = x_i & y_i;
      OP_OR:     res_o = x_i | y_i;
      OP_XOR:    res_o = x_i ^ y_i;
      OP_SHL:    res_o = sat ? '0 : (x_i << n);
      OP_SHR:    res_o = sat ? '0 : (x_i >> n);
      OP_SAR:    res_o = WORD_W'($signed(x_i) >>> (sat ? 5'd31 : n));
      OP_ROL:    res_o = (x_i << n) | (x_i >> (6'd32 - {1'b0, n}));
      OP_ROR:    res_o = (x_i >> n) | (x_i << (6'd32 - {1'b0, n}));
      OP_GET:    res_o = WORD_W'((x_i >> n) & WORD_W'(1));
      OP_SET:    res_o = x_i | bit_mask;
      OP_CLR:    res_o = x_i & ~bit_mask;
      OP_TGL:    res_o = x_i ^ bit_mask;
      OP_NOT:    res_o = ~y_i;
      OP_POPCNT: res_o = WORD_W'($countones(y_i));
      OP_CLZ:    res_o = WORD_W'(lz);
      OP_CTZ:    res_o = WORD_W'(tz);
      OP_BSWAP:  res_o = {y_i[7:0], y_i[15:8], y_i[23:16], y_i[31:24]};
      default:   res_o = '0;
    endcase
  end

endmodule

// ----- sv/sbe_stack.sv -----
// Operand stack as a shift line with the top at entry zero, plus its depth counter.
module sbe_stack import sbe_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DEF,
  localparam int DW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stk_ctl_t          ctl_i,
  output logic [WORD_W-1:0] top_o,
  output logic [WORD_W-1:0] next_o,
  output logic [DW-1:0]     depth_o,
  output logic [WORD_W-1:0] top_nx_o,
  output logic [DW-1:0]     depth_nx_o
);

  logic [WORD_W-1:0] stk_q [DEPTH];
  logic [WORD_W-1:0] stk_d [DEPTH];
  logic [DW-1:0]     depth_q;

  assign top_o   = stk_q[0];
  assign next_o  = stk_q[1];
  assign depth_o = depth_q;

  always_comb begin
    stk_d      = stk_q;
    depth_nx_o = depth_q;
    case (ctl_i.cmd)
      STK_PUSH: begin
        stk_d[0] = ctl_i.data;
        for (int i = 1; i < DEPTH; i++) begin
          stk_d[i] = stk_q[i-1];
        end
        depth_nx_o = depth_q + DW'(1);
      end
      STK_POP: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          stk_d[i] = stk_q[i+1];
        end
        depth_nx_o = depth_q - DW'(1);
      end
      STK_SWAP: begin
        stk_d[0] = stk_q[1];
        stk_d[1] = stk_q[0];
      end
      STK_REPL: begin
        stk_d[0] = ctl_i.data;
      end
      STK_BIN: begin
        stk_d[0] = ctl_i.data;
        for (int i = 1; i < DEPTH - 1; i++) begin
          stk_d[i] = stk_q[i+1];
        end
        depth_nx_o = depth_q - DW'(1);
      end
      default: begin
        stk_d = stk_q;
      end
    endcase
    top_nx_o = stk_d[0];
  end

  always_ff @(posedge clk_i) begin
    stk_q <= stk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (ctl_i.clear) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_nx_o;
    end
  end

endmodule

// ----- sv/stack_bit_expression_evaluator.sv -----
// Stack bit expression evaluator top level: item register, decode and execute, result register.
// Takes one item per clock unless a last byte waits on a held result: slot writes for pins and
// constants, or one bytecode byte of a program. Each byte is decoded and executed from the item
// register, with the pin and constant tables read at the accept edge so their data is ready for
// it; a result is registered after the byte marked last and held until taken while the next
// program's bytes stream in. The user must write configuration through the plain write port
// while no transaction is in flight; the block does not enforce it. No clearing pass after reset.
module stack_bit_expression_evaluator import sbe_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int PIN_SLOTS   = PIN_SLOTS_DEF,
  parameter int CONST_SLOTS = CONST_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COUNT_W-1:0]   cfg_wdata_i,
  sbe_in_if.sink               in_ch,
  sbe_out_if.source            out_ch
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [COUNT_W-1:0] pin_cnt_q;
  logic [COUNT_W-1:0] const_cnt_q;

  logic               in_fire;
  logic               ex_valid_q;
  logic [OPER_W-1:0]  ex_oper_q;
  logic [BYTE_W-1:0]  ex_byte_q;
  logic               ex_last_q;
  logic [WORD_W-1:0]  pin_rd;
  logic [WORD_W-1:0]  const_rd;
  logic               produce;
  logic               out_free;
  logic               ex_go;
  logic               code_go;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic               await_q, await_d;
  logic               pendk_q, pendk_d;
  logic               ended_q, ended_d;
  logic [STAT_W-1:0]  err_q, err_d;
  logic [POS_W-1:0]   errpos_q, errpos_d;
  logic [BYTE_W-1:0]  errop_q, errop_d;

  logic [STAT_W-1:0]  fin_err;
  logic [POS_W-1:0]   fin_pos;
  logic [BYTE_W-1:0]  fin_op;

  logic               out_valid_q;
  logic [WORD_W-1:0]  out_res_q, out_res_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [BYTE_W-1:0]  out_op_q, out_op_d;

  stk_ctl_t           stk_ctl;
  logic [WORD_W-1:0]  stk_top;
  logic [WORD_W-1:0]  stk_next;
  logic [DW-1:0]      stk_depth;
  logic [WORD_W-1:0]  stk_top_nx;
  logic [DW-1:0]      stk_depth_nx;
  logic [WORD_W-1:0]  alu_res;

  logic               active;
  logic               full;
  logic               idx_ok;
  logic [BYTE_W-1:0]  pend_op;
  logic               is_bin;
  logic               need_two;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign produce  = ex_valid_q && (ex_oper_q == OPN_CODE) && ex_last_q;
  assign out_free = !out_valid_q || out_ch.ready;
  assign ex_go    = ex_valid_q && (!produce || out_free);
  assign code_go  = ex_go && (ex_oper_q == OPN_CODE);
  assign in_ch.ready = !ex_valid_q || ex_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_cnt_q   <= '0;
      const_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIN_COUNT:   pin_cnt_q   <= cfg_wdata_i;
        CFG_CONST_COUNT: const_cnt_q <= cfg_wdata_i;
        default: begin
          pin_cnt_q <= pin_cnt_q;
        end
      endcase
    end
  end

  sbe_slot_ram #(.SLOTS(PIN_SLOTS)) u_pin_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_ch.operation == OPN_PIN)),
    .waddr_i (in_ch.slot),
    .wdata_i (in_ch.value),
    .re_i    (in_fire),
    .raddr_i (in_ch.code_byte),
    .rdata_o (pin_rd)
  );

  sbe_slot_ram #(.SLOTS(CONST_SLOTS)) u_const_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_ch.operation == OPN_CONST)),
    .waddr_i (in_ch.slot),
    .wdata_i (in_ch.value),
    .re_i    (in_fire),
    .raddr_i (in_ch.code_byte),
    .rdata_o (const_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      ex_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_oper_q <= in_ch.operation;
      ex_byte_q <= in_ch.code_byte;
      ex_last_q <= in_ch.last;
    end
  end

  sbe_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (stk_ctl),
    .top_o      (stk_top),
    .next_o     (stk_next),
    .depth_o    (stk_depth),
    .top_nx_o   (stk_top_nx),
    .depth_nx_o (stk_depth_nx)
  );

  sbe_alu u_alu (
    .op_i  (ex_byte_q),
    .x_i   (stk_next),
    .y_i   (stk_top),
    .res_o (alu_res)
  );

  assign active   = !ended_q && (err_q == ST_OK);
  assign full     = stk_depth >= DW'(STACK_DEPTH);
  assign pend_op  = pendk_q ? OP_K : OP_IN;
  assign is_bin   = (ex_byte_q >= OP_AND) && (ex_byte_q <= OP_TGL);
  assign need_two = is_bin || (ex_byte_q == OP_SWAP);
  assign idx_ok   = pendk_q ?
                    ((ex_byte_q < BYTE_W'(const_cnt_q)) && (32'(ex_byte_q) < CONST_SLOTS)) :
                    ((ex_byte_q < BYTE_W'(pin_cnt_q)) && (32'(ex_byte_q) < PIN_SLOTS));

  always_comb begin
    stk_ctl.cmd   = STK_HOLD;
    stk_ctl.clear = 1'b0;
    stk_ctl.data  = alu_res;
    pos_d    = pos_q;
    await_d  = await_q;
    pendk_d  = pendk_q;
    ended_d  = ended_q;
    err_d    = err_q;
    errpos_d = errpos_q;
    errop_d  = errop_q;
    fin_err  = ST_OK;
    fin_pos  = '0;
    fin_op   = OP_END;
    if (code_go) begin
      pos_d = pos_q + POS_W'(1);
      if (active) begin
        if (await_q) begin
          await_d = 1'b0;
          if (!idx_ok) begin
            err_d    = ST_OPERAND;
            errpos_d = pos_q - POS_W'(1);
            errop_d  = pend_op;
          end else if (full) begin
            err_d    = ST_OVER;
            errpos_d = pos_q - POS_W'(1);
            errop_d  = pend_op;
          end else begin
            stk_ctl.cmd  = STK_PUSH;
            stk_ctl.data = pendk_q ? const_rd : pin_rd;
          end
        end else if (ex_byte_q == OP_END) begin
          ended_d = 1'b1;
        end else if ((ex_byte_q == OP_IN) || (ex_byte_q == OP_K)) begin
          await_d = 1'b1;
          pendk_d = (ex_byte_q == OP_K);
        end else if (ex_byte_q > OP_BSWAP) begin
          err_d    = ST_OPCODE;
          errpos_d = pos_q;
          errop_d  = ex_byte_q;
        end else if (stk_depth < (need_two ? DW'(2) : DW'(1))) begin
          err_d    = ST_UNDER;
          errpos_d = pos_q;
          errop_d  = ex_byte_q;
        end else begin
          case (ex_byte_q)
            OP_DUP: begin
              if (full) begin
                err_d    = ST_OVER;
                errpos_d = pos_q;
                errop_d  = ex_byte_q;
              end else begin
                stk_ctl.cmd  = STK_PUSH;
                stk_ctl.data = stk_top;
              end
            end
            OP_DROP: stk_ctl.cmd = STK_POP;
            OP_SWAP: stk_ctl.cmd = STK_SWAP;
            default: stk_ctl.cmd = is_bin ? STK_BIN : STK_REPL;
          endcase
        end
      end
      if (ex_last_q) begin
        if (await_d && (err_d == ST_OK)) begin
          err_d    = ST_OPERAND;
          errpos_d = pos_q;
          errop_d  = pendk_d ? OP_K : OP_IN;
        end
        fin_err = err_d;
        fin_pos = errpos_d;
        fin_op  = errop_d;
        stk_ctl.clear = 1'b1;
        pos_d    = '0;
        await_d  = 1'b0;
        pendk_d  = 1'b0;
        ended_d  = 1'b0;
        err_d    = ST_OK;
        errpos_d = '0;
        errop_d  = OP_END;
      end
    end
  end

  always_comb begin
    out_res_d  = '0;
    out_stat_d = fin_err;
    out_pos_d  = fin_pos;
    out_op_d   = fin_op;
    if (fin_err == ST_OK) begin
      if (stk_depth_nx != DW'(1)) begin
        out_stat_d = ST_DEPTH;
        out_pos_d  = pos_q + POS_W'(1);
        out_op_d   = OP_END;
      end else begin
        out_res_d = stk_top_nx;
        out_pos_d = '0;
        out_op_d  = OP_END;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      await_q  <= 1'b0;
      pendk_q  <= 1'b0;
      ended_q  <= 1'b0;
      err_q    <= ST_OK;
      errpos_q <= '0;
      errop_q  <= OP_END;
    end else begin
      pos_q    <= pos_d;
      await_q  <= await_d;
      pendk_q  <= pendk_d;
      ended_q  <= ended_d;
      err_q    <= err_d;
      errpos_q <= errpos_d;
      errop_q  <= errop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_go && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_go && produce) begin
      out_res_q  <= out_res_d;
      out_stat_q <= out_stat_d;
      out_pos_q  <= out_pos_d;
      out_op_q   <= out_op_d;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.result         = out_res_q;
  assign out_ch.status         = out_stat_q;
  assign out_ch.error_position = out_pos_q;
  assign out_ch.error_opcode   = out_op_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_go && produce |=> (err_q == ST_OK) && (pos_q == '0) && !await_q && (stk_depth == '0))
    else $error("program state not cleared after result");

  a_ok_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_stat_q == ST_OK) |-> (out_pos_q == '0) && (out_op_q == OP_END))
    else $error("good result carries error fields");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_end_no_await: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ended_q && await_q))
    else $error("operand pending after END");

endmodule
